// ===== rtl/kwr_pkg.sv =====
package kwr_pkg;

   localparam int BUFFER_DEPTH_DEF  = 16;
   localparam int TABLE_ENTRIES_DEF = 12;
   localparam int MAX_REPLACEMENT   = 40;
   localparam int STORED_PAIRS      = 12;
   localparam int KEY_SLOTS         = 10;

   localparam int DICT_IDX_W = $clog2(STORED_PAIRS);
   localparam int KEY_IDX_W  = $clog2(KEY_SLOTS + 1);
   localparam int TEXT_IDX_W = $clog2(MAX_REPLACEMENT + 1);
   localparam int LETTER_W   = 5;
   localparam int CHAR_W     = 7;

   localparam logic [CHAR_W-1:0] LETTER_FIRST = 7'd65;
   localparam logic [CHAR_W-1:0] LETTER_LAST  = 7'd90;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'd32;
   localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'd0;

   localparam logic KIND_BACKSPACE = 1'b0;
   localparam logic KIND_CHAR      = 1'b1;

   typedef enum logic [1:0] {
      OP_LETTER    = 2'd0,
      OP_SPACE     = 2'd1,
      OP_BACKSPACE = 2'd2,
      OP_ENTER     = 2'd3
   } opcode_type;

   typedef logic [8*KEY_SLOTS-1:0]       key_str_type;
   typedef logic [8*MAX_REPLACEMENT-1:0] text_str_type;

   // Strings sit right-justified: the first character is the highest nonzero byte.
   localparam key_str_type DICT_KEYS [STORED_PAIRS] = '{
      "GRIEF", "HEARTBREAK", "LONELINESS", "ANGUISH", "BROKEN", "GRIEVED",
      "HURT", "JOYLESS", "MOROSE", "PATHETIC", "WEEPING", "SULLEN"
   };

   localparam text_str_type DICT_TEXTS [STORED_PAIRS] = '{
      "Bursting with jo",
      "Excitement fills the ai",
      "Hope sparks the sou",
      "Delightful moments of blis",
      "Fulfilled with a grateful hear",
      "Thriving in a state of blis",
      "Uplifted by the power of positivit",
      "Excited for the journey ahea",
      "Ecstatic with pure jo",
      "Optimistic about tomorrow's blessing",
      "Grateful for the present momen",
      "Harmonious unity in diversit"
   };

   function automatic int unsigned count_chars(text_str_type s);
      int unsigned n;
      n = 0;
      for (int i = 0; i < MAX_REPLACEMENT; i++) begin
         if (s[8*i +: 8] != 8'd0) n++;
      end
      return n;
   endfunction

   function automatic logic [KEY_IDX_W-1:0] key_len_of(int e);
      return KEY_IDX_W'(count_chars(text_str_type'(DICT_KEYS[e])));
   endfunction

   function automatic logic [TEXT_IDX_W-1:0] text_len_of(int e);
      return TEXT_IDX_W'(count_chars(DICT_TEXTS[e]));
   endfunction

   localparam logic [KEY_IDX_W-1:0] KEY_LEN [STORED_PAIRS] = '{
      key_len_of(0), key_len_of(1), key_len_of(2), key_len_of(3),
      key_len_of(4), key_len_of(5), key_len_of(6), key_len_of(7),
      key_len_of(8), key_len_of(9), key_len_of(10), key_len_of(11)
   };

   localparam logic [TEXT_IDX_W-1:0] TEXT_LEN [STORED_PAIRS] = '{
      text_len_of(0), text_len_of(1), text_len_of(2), text_len_of(3),
      text_len_of(4), text_len_of(5), text_len_of(6), text_len_of(7),
      text_len_of(8), text_len_of(9), text_len_of(10), text_len_of(11)
   };

   function automatic logic [KEY_IDX_W-1:0] dict_key_len(logic [DICT_IDX_W-1:0] e);
      logic [KEY_IDX_W-1:0] len;
      len = '0;
      if (int'(e) < STORED_PAIRS) len = KEY_LEN[e];
      return len;
   endfunction

   function automatic logic [TEXT_IDX_W-1:0] dict_text_len(logic [DICT_IDX_W-1:0] e);
      logic [TEXT_IDX_W-1:0] len;
      len = '0;
      if (int'(e) < STORED_PAIRS) len = TEXT_LEN[e];
      return len;
   endfunction

   function automatic logic [CHAR_W-1:0] dict_key_char(logic [DICT_IDX_W-1:0] e,
                                                       logic [KEY_IDX_W-1:0] i);
      key_str_type       k;
      int                pos;
      logic [CHAR_W-1:0] ch;
      ch = CHAR_NONE;
      if (int'(e) < STORED_PAIRS) begin
         k = DICT_KEYS[e];
         if (i < KEY_LEN[e]) begin
            pos = int'(KEY_LEN[e]) - 1 - int'(i);
            ch  = k[8*pos +: CHAR_W];
         end
      end
      return ch;
   endfunction

   function automatic logic [CHAR_W-1:0] dict_text_char(logic [DICT_IDX_W-1:0] e,
                                                        logic [TEXT_IDX_W-1:0] i);
      text_str_type      t;
      int                pos;
      logic [CHAR_W-1:0] ch;
      ch = CHAR_NONE;
      if (int'(e) < STORED_PAIRS) begin
         t = DICT_TEXTS[e];
         if (i < TEXT_LEN[e]) begin
            pos = int'(TEXT_LEN[e]) - 1 - int'(i);
            ch  = t[8*pos +: CHAR_W];
         end
      end
      return ch;
   endfunction

endpackage

// ===== rtl/kwr_ram.sv =====
module kwr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/keystroke_word_replacer_top.sv =====
// Keystroke word replacer.
// req channel: one keyboard event per beat. req_tuser carries the event kind
// (letter, space, backspace, enter), req_tdata the ASCII letter for a letter.
// rsp channel: one emitted key per beat. rsp_tuser is the key kind (backspace
// or printable), rsp_tdata the character, rsp_tlast marks the final key of a run.
// Letter, backspace and enter beats emit nothing; letters land in the word
// buffer RAM. A space on a nonempty, non-overflowed word scans the dictionary
// entry by entry and compares letter by letter, since every letter comes back
// through the buffer RAM's single registered read port; any other space drops
// the word. On a match the run of length+1 backspaces, the replacement text and
// a closing space leaves at one beat per cycle while rsp is not stalled.
// req_tready is high only between events, so one event is handled at a time;
// the final key of a run may still wait in the output register while the next
// events are taken.
// A stall on rsp holds the output register and the sequencer until the beat
// is taken. Reset clears the word length, the overflow flag, the sequencer and
// the output valid; the buffer RAM is not cleared since only written entries
// are ever read.
module keystroke_word_replacer_top
   import kwr_pkg::*;
#(
   parameter int BUFFER_DEPTH  = BUFFER_DEPTH_DEF,
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [6:0] letter_code, [7] zero
   input  logic [1:0] req_tuser,   // [1:0] opcode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] char_code, [7] zero
   output logic       rsp_tuser,   // [0] key_kind
   output logic       rsp_tlast
);

   localparam int LIMIT  = (TABLE_ENTRIES < STORED_PAIRS) ? TABLE_ENTRIES : STORED_PAIRS;
   localparam int ENT_W  = $clog2(LIMIT + 1);
   localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1);
   localparam int ADDR_W = $clog2(BUFFER_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_CMP,
      ST_EMIT_BS,
      ST_EMIT_TXT,
      ST_EMIT_SP
   } state_type;

   state_type               state_ff, state_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    ovf_ff, ovf_in;
   logic [ENT_W-1:0]        entry_ff, entry_in;
   logic [KEY_IDX_W-1:0]    idx_ff, idx_in;
   logic [LEN_W-1:0]        cnt_ff, cnt_in;
   logic [TEXT_IDX_W-1:0]   tpos_ff, tpos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_accept;
   logic                    out_free;
   opcode_type              opcode;
   logic [CHAR_W-1:0]       letter_code;
   logic [DICT_IDX_W-1:0]   key_sel;
   logic [KEY_IDX_W-1:0]    key_len;
   logic [TEXT_IDX_W-1:0]   text_len;
   logic [CHAR_W-1:0]       key_char;
   logic [CHAR_W-1:0]       text_char;
   logic [CHAR_W-1:0]       stored_char;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_wa;
   logic [LETTER_W-1:0]     ram_wd;
   logic [ADDR_W-1:0]       ram_ra;
   logic [LETTER_W-1:0]     ram_rd;

   kwr_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign opcode      = opcode_type'(req_tuser);
   assign letter_code = req_tdata[CHAR_W-1:0];
   assign out_free    = !rsp_valid_ff || rsp_tready;

   assign key_sel     = DICT_IDX_W'(entry_ff);
   assign key_len     = dict_key_len(key_sel);
   assign text_len    = dict_text_len(key_sel);
   assign key_char    = dict_key_char(key_sel, idx_ff);
   assign text_char   = dict_text_char(key_sel, tpos_ff);
   assign stored_char = LETTER_FIRST + CHAR_W'(ram_rd);

   // Writes happen only in idle and reads only while matching: the ports never overlap.
   assign ram_wa = len_ff[ADDR_W-1:0];
   assign ram_wd = LETTER_W'(letter_code - LETTER_FIRST);
   assign ram_ra = ADDR_W'(idx_ff);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      entry_in     = entry_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      tpos_in      = tpos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (opcode)
                  OP_LETTER: begin
                     if (letter_code >= LETTER_FIRST && letter_code <= LETTER_LAST) begin
                        if (len_ff < LEN_W'(BUFFER_DEPTH)) begin
                           ram_we = 1'b1;
                           len_in = len_ff + 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end
                  OP_BACKSPACE: begin
                     if (len_ff != '0) len_in = len_ff - 1'b1;
                  end
                  OP_ENTER: begin
                     len_in = '0;
                     ovf_in = 1'b0;
                  end
                  OP_SPACE: begin
                     if (!ovf_ff && len_ff != '0) begin
                        entry_in = '0;
                        state_in = ST_CHECK;
                     end else begin
                        len_in = '0;
                        ovf_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_CHECK: begin
            if (entry_ff == ENT_W'(LIMIT)) begin
               // no entry matched: drop the word
               len_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else if (LEN_W'(key_len) == len_ff) begin
               idx_in   = '0;
               state_in = ST_READ;
            end else begin
               entry_in = entry_ff + 1'b1;
            end
         end

         ST_READ: begin
            state_in = ST_CMP;
         end

         ST_CMP: begin
            if (key_char != stored_char) begin
               entry_in = entry_ff + 1'b1;
               state_in = ST_CHECK;
            end else if (idx_ff == key_len - 1'b1) begin
               cnt_in   = '0;
               state_in = ST_EMIT_BS;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end

         ST_EMIT_BS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_BACKSPACE;
               rsp_char_in  = CHAR_NONE;
               rsp_last_in  = 1'b0;
               if (cnt_ff == len_ff) begin
                  tpos_in  = '0;
                  state_in = ST_EMIT_TXT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         ST_EMIT_TXT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CHAR;
               rsp_char_in  = text_char;
               rsp_last_in  = 1'b0;
               if (tpos_ff == text_len - 1'b1) begin
                  state_in = ST_EMIT_SP;
               end else begin
                  tpos_in = tpos_ff + 1'b1;
               end
            end
         end

         ST_EMIT_SP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CHAR;
               rsp_char_in  = CHAR_SPACE;
               rsp_last_in  = 1'b1;
               len_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      entry_ff    <= entry_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      tpos_ff     <= tpos_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(BUFFER_DEPTH))
      else $error("word length beyond buffer depth");

   a_mid_run_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == ST_EMIT_BS ||
                                          state_ff == ST_EMIT_TXT ||
                                          state_ff == ST_EMIT_SP))
      else $error("non-final key pending outside of emission");

   a_bs_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_BACKSPACE) |-> !rsp_last_ff)
      else $error("backspace key marked as final key");
`endif

endmodule
